// ----- rtl/rarbs_pkg.sv -----
// Shared constants, command codes and the control bundle for the blocked
// range add / range sum engine. No dependencies; every file but rarbs_ram uses it.
package rarbs_pkg;

   localparam int IDX_W      = 10;
   localparam int CFG_W      = 11;
   localparam int VAL_W      = 32;
   localparam int DATA_W     = 64;
   localparam int MAX_ELEMS  = 1 << IDX_W;
   localparam int BLOCK_BITS = 5;
   localparam int BLK_ELEMS  = 1 << BLOCK_BITS;
   localparam int BLK_W      = IDX_W - BLOCK_BITS;
   localparam int NUM_BLOCKS = 1 << BLK_W;

   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_SUM   = 2'd1;
   localparam logic [1:0] CMD_WRITE = 2'd2;

   localparam logic STATUS_DONE  = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;

   // Per-cycle operation handed from the sequencer to the storage datapath.
   typedef struct packed {
      logic              clear;
      logic              acc_clear;
      logic              is_add;
      logic              elem_rd_en;
      logic              blk_rd_en;
      logic [IDX_W-1:0]  elem_addr;
      logic [BLK_W-1:0]  blk_addr;
      logic              p1_elem;
      logic              p1_whole;
      logic [IDX_W-1:0]  p1_idx;
      logic [BLK_W-1:0]  p1_blk;
      logic              fin;
      logic              wr_wb;
      logic [DATA_W-1:0] x;
   } op_type;

endpackage

// ----- rtl/rarbs_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module rarbs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // The read register holds its value until the next read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rarbs_store.sv -----
// Element store, block sum and pending-add memories with their update logic.
// Depends on rarbs_pkg and rarbs_ram.
module rarbs_store (
   input  logic                     clock,
   input  rarbs_pkg::op_type        op,
   output logic [rarbs_pkg::DATA_W-1:0] acc
);

   logic [rarbs_pkg::DATA_W-1:0] elem_rd;
   logic [rarbs_pkg::DATA_W-1:0] pend_rd;
   logic [rarbs_pkg::DATA_W-1:0] bsum_rd;

   logic                          elem_we;
   logic [rarbs_pkg::IDX_W-1:0]   elem_wa;
   logic [rarbs_pkg::DATA_W-1:0]  elem_wd;
   logic                          pend_we;
   logic [rarbs_pkg::BLK_W-1:0]   pend_wa;
   logic [rarbs_pkg::DATA_W-1:0]  pend_wd;
   logic                          bsum_we;
   logic [rarbs_pkg::BLK_W-1:0]   bsum_wa;
   logic [rarbs_pkg::DATA_W-1:0]  bsum_wd;

   logic [rarbs_pkg::DATA_W-1:0]  acc_ff;
   logic [rarbs_pkg::DATA_W-1:0]  acc_in;
   logic [rarbs_pkg::DATA_W-1:0]  delta_ff;
   logic [rarbs_pkg::DATA_W-1:0]  delta_in;
   logic [rarbs_pkg::DATA_W-1:0]  old_val;

   always_comb begin
      elem_we  = 1'b0;
      elem_wa  = op.elem_addr;
      elem_wd  = '0;
      pend_we  = 1'b0;
      pend_wa  = op.blk_addr;
      pend_wd  = '0;
      bsum_we  = 1'b0;
      bsum_wa  = op.blk_addr;
      bsum_wd  = '0;
      acc_in   = acc_ff;
      delta_in = delta_ff;
      old_val  = elem_rd + pend_rd;

      if (op.clear) begin
         elem_we = 1'b1;
         if (op.elem_addr < rarbs_pkg::IDX_W'(rarbs_pkg::NUM_BLOCKS)) begin
            pend_we = 1'b1;
            bsum_we = 1'b1;
            pend_wa = op.elem_addr[rarbs_pkg::BLK_W-1:0];
            bsum_wa = op.elem_addr[rarbs_pkg::BLK_W-1:0];
         end
      end

      // Element stage: the block tag read at segment start stays on pend_rd.
      if (op.p1_elem) begin
         if (op.is_add) begin
            elem_we  = 1'b1;
            elem_wa  = op.p1_idx;
            elem_wd  = elem_rd + op.x;
            delta_in = delta_ff + op.x;
         end else begin
            acc_in = acc_ff + elem_rd + pend_rd;
         end
      end

      if (op.p1_whole) begin
         if (op.is_add) begin
            pend_we = 1'b1;
            pend_wa = op.p1_blk;
            pend_wd = pend_rd + op.x;
            bsum_we = 1'b1;
            bsum_wa = op.p1_blk;
            bsum_wd = bsum_rd + (op.x << rarbs_pkg::BLOCK_BITS);
         end else begin
            acc_in = acc_ff + bsum_rd;
         end
      end

      // End of a partial block: fold the collected increase into its sum.
      if (op.fin) begin
         if (op.is_add) begin
            bsum_we = 1'b1;
            bsum_wd = bsum_rd + delta_ff;
         end
         delta_in = '0;
      end

      if (op.wr_wb) begin
         elem_we = 1'b1;
         elem_wd = op.x - pend_rd;
         bsum_we = 1'b1;
         bsum_wd = bsum_rd + op.x - old_val;
      end

      if (op.acc_clear) begin
         acc_in   = '0;
         delta_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      delta_ff <= delta_in;
   end

   assign acc = acc_ff;

   rarbs_ram #(
      .WIDTH (rarbs_pkg::DATA_W),
      .DEPTH (rarbs_pkg::MAX_ELEMS)
   ) u_elem_ram (
      .clock   (clock),
      .wr_en   (elem_we),
      .wr_addr (elem_wa),
      .wr_data (elem_wd),
      .rd_en   (op.elem_rd_en),
      .rd_addr (op.elem_addr),
      .rd_data (elem_rd)
   );

   rarbs_ram #(
      .WIDTH (rarbs_pkg::DATA_W),
      .DEPTH (rarbs_pkg::NUM_BLOCKS)
   ) u_pend_ram (
      .clock   (clock),
      .wr_en   (pend_we),
      .wr_addr (pend_wa),
      .wr_data (pend_wd),
      .rd_en   (op.blk_rd_en),
      .rd_addr (op.blk_addr),
      .rd_data (pend_rd)
   );

   rarbs_ram #(
      .WIDTH (rarbs_pkg::DATA_W),
      .DEPTH (rarbs_pkg::NUM_BLOCKS)
   ) u_bsum_ram (
      .clock   (clock),
      .wr_en   (bsum_we),
      .wr_addr (bsum_wa),
      .wr_data (bsum_wd),
      .rd_en   (op.blk_rd_en),
      .rd_addr (op.blk_addr),
      .rd_data (bsum_rd)
   );

endmodule

// ----- rtl/rarbs_ctrl.sv -----
// Command sequencer: decodes requests, walks partial blocks and whole
// blocks, runs the reset clearing pass and holds the result register.
// Depends on rarbs_pkg.
module rarbs_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [1:0]                    req_cmd,
   input  logic [rarbs_pkg::IDX_W-1:0]   req_lo,
   input  logic [rarbs_pkg::IDX_W-1:0]   req_hi,
   input  logic [rarbs_pkg::VAL_W-1:0]   req_value,
   input  logic                          csr_wr_en,
   input  logic [rarbs_pkg::CFG_W-1:0]   csr_wr_data,
   input  logic [rarbs_pkg::DATA_W-1:0]  acc,
   output rarbs_pkg::op_type             op,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [rarbs_pkg::DATA_W-1:0]  rsp_sum,
   output logic                          rsp_status
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_ELEM, S_ELEM_DRAIN, S_ELEM_FIN,
      S_WHOLE, S_WHOLE_DRAIN, S_WR_RD, S_WR_WB, S_DONE
   } state_type;

   state_type                     state_ff, state_in;
   logic [rarbs_pkg::CFG_W-1:0]   elems_ff, elems_in;
   logic [1:0]                    cmd_ff, cmd_in;
   logic [rarbs_pkg::IDX_W-1:0]   cur_idx_ff, cur_idx_in;
   logic [rarbs_pkg::IDX_W-1:0]   end_idx_ff, end_idx_in;
   logic [rarbs_pkg::IDX_W-1:0]   hi_ff, hi_in;
   logic [rarbs_pkg::BLK_W-1:0]   cur_blk_ff, cur_blk_in;
   logic [rarbs_pkg::BLK_W-1:0]   br_ff, br_in;
   logic                          first_ff, first_in;
   logic [rarbs_pkg::DATA_W-1:0]  x_ff, x_in;
   logic                          status_ff, status_in;
   logic                          p1_elem_ff, p1_elem_in;
   logic                          p1_whole_ff, p1_whole_in;
   logic [rarbs_pkg::IDX_W-1:0]   p1_idx_ff, p1_idx_in;
   logic [rarbs_pkg::BLK_W-1:0]   p1_blk_ff, p1_blk_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [rarbs_pkg::DATA_W-1:0]  rsp_sum_ff, rsp_sum_in;
   logic                          rsp_status_ff, rsp_status_in;

   logic                          accept;
   logic [rarbs_pkg::CFG_W-1:0]   n_eff;
   logic [rarbs_pkg::IDX_W-1:0]   n_last;
   logic [rarbs_pkg::IDX_W-1:0]   hi_c;
   logic [rarbs_pkg::BLK_W-1:0]   lo_blk;
   logic [rarbs_pkg::BLK_W-1:0]   hi_blk;
   logic                          more_whole;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (elems_ff == '0) begin
         n_eff = rarbs_pkg::CFG_W'(1);
      end else if (elems_ff > rarbs_pkg::CFG_W'(rarbs_pkg::MAX_ELEMS)) begin
         n_eff = rarbs_pkg::CFG_W'(rarbs_pkg::MAX_ELEMS);
      end else begin
         n_eff = elems_ff;
      end
      n_last     = rarbs_pkg::IDX_W'(n_eff - rarbs_pkg::CFG_W'(1));
      hi_c       = (req_hi > n_last) ? n_last : req_hi;
      lo_blk     = req_lo[rarbs_pkg::IDX_W-1:rarbs_pkg::BLOCK_BITS];
      hi_blk     = hi_c[rarbs_pkg::IDX_W-1:rarbs_pkg::BLOCK_BITS];
      more_whole = ({1'b0, br_ff} > ({1'b0, cur_blk_ff} + (rarbs_pkg::BLK_W+1)'(1)));
   end

   always_comb begin
      state_in      = state_ff;
      elems_in      = elems_ff;
      cmd_in        = cmd_ff;
      cur_idx_in    = cur_idx_ff;
      end_idx_in    = end_idx_ff;
      hi_in         = hi_ff;
      cur_blk_in    = cur_blk_ff;
      br_in         = br_ff;
      first_in      = first_ff;
      x_in          = x_ff;
      status_in     = status_ff;
      p1_elem_in    = (state_ff == S_ELEM);
      p1_whole_in   = (state_ff == S_WHOLE);
      p1_idx_in     = cur_idx_ff;
      p1_blk_in     = cur_blk_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_sum_in    = rsp_sum_ff;
      rsp_status_in = rsp_status_ff;

      if (csr_wr_en) begin
         elems_in = csr_wr_data;
      end

      case (state_ff)
         S_CLEAR: begin
            if (cur_idx_ff == rarbs_pkg::IDX_W'(rarbs_pkg::MAX_ELEMS - 1)) begin
               state_in = S_IDLE;
            end else begin
               cur_idx_in = cur_idx_ff + rarbs_pkg::IDX_W'(1);
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd_in     = req_cmd;
               x_in       = {{(rarbs_pkg::DATA_W-rarbs_pkg::VAL_W){req_value[rarbs_pkg::VAL_W-1]}},
                             req_value};
               cur_idx_in = req_lo;
               cur_blk_in = lo_blk;
               br_in      = hi_blk;
               hi_in      = hi_c;
               first_in   = 1'b1;
               status_in  = rarbs_pkg::STATUS_DONE;
               end_idx_in = (lo_blk == hi_blk) ? hi_c
                            : {lo_blk, {rarbs_pkg::BLOCK_BITS{1'b1}}};
               case (req_cmd)
                  rarbs_pkg::CMD_ADD, rarbs_pkg::CMD_SUM: begin
                     if (req_lo > hi_c) begin
                        status_in = rarbs_pkg::STATUS_EMPTY;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_ELEM;
                     end
                  end
                  rarbs_pkg::CMD_WRITE: begin
                     if ({1'b0, req_lo} >= n_eff) begin
                        status_in = rarbs_pkg::STATUS_EMPTY;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_WR_RD;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_ELEM: begin
            first_in = 1'b0;
            if (cur_idx_ff == end_idx_ff) begin
               state_in = S_ELEM_DRAIN;
            end else begin
               cur_idx_in = cur_idx_ff + rarbs_pkg::IDX_W'(1);
            end
         end
         S_ELEM_DRAIN: begin
            state_in = S_ELEM_FIN;
         end
         S_ELEM_FIN: begin
            if (cur_blk_ff == br_ff) begin
               state_in = S_DONE;
            end else if (more_whole) begin
               cur_blk_in = cur_blk_ff + rarbs_pkg::BLK_W'(1);
               state_in   = S_WHOLE;
            end else begin
               cur_blk_in = br_ff;
               cur_idx_in = {br_ff, {rarbs_pkg::BLOCK_BITS{1'b0}}};
               end_idx_in = hi_ff;
               first_in   = 1'b1;
               state_in   = S_ELEM;
            end
         end
         S_WHOLE: begin
            if (cur_blk_ff == br_ff - rarbs_pkg::BLK_W'(1)) begin
               state_in = S_WHOLE_DRAIN;
            end else begin
               cur_blk_in = cur_blk_ff + rarbs_pkg::BLK_W'(1);
            end
         end
         S_WHOLE_DRAIN: begin
            cur_blk_in = br_ff;
            cur_idx_in = {br_ff, {rarbs_pkg::BLOCK_BITS{1'b0}}};
            end_idx_in = hi_ff;
            first_in   = 1'b1;
            state_in   = S_ELEM;
         end
         S_WR_RD: begin
            state_in = S_WR_WB;
         end
         S_WR_WB: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            // The accumulator stays zero for every command but a range sum.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_sum_in    = acc;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         elems_ff     <= rarbs_pkg::CFG_W'(rarbs_pkg::MAX_ELEMS);
         cur_idx_ff   <= '0;
         p1_elem_ff   <= 1'b0;
         p1_whole_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         elems_ff     <= elems_in;
         cur_idx_ff   <= cur_idx_in;
         p1_elem_ff   <= p1_elem_in;
         p1_whole_ff  <= p1_whole_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      end_idx_ff    <= end_idx_in;
      hi_ff         <= hi_in;
      cur_blk_ff    <= cur_blk_in;
      br_ff         <= br_in;
      first_ff      <= first_in;
      x_ff          <= x_in;
      status_ff     <= status_in;
      p1_idx_ff     <= p1_idx_in;
      p1_blk_ff     <= p1_blk_in;
      rsp_sum_ff    <= rsp_sum_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      op.clear      = (state_ff == S_CLEAR);
      op.acc_clear  = accept;
      op.is_add     = (cmd_ff == rarbs_pkg::CMD_ADD);
      op.elem_rd_en = (state_ff == S_ELEM) || (state_ff == S_WR_RD);
      op.blk_rd_en  = ((state_ff == S_ELEM) && first_ff) || (state_ff == S_WHOLE) ||
                      (state_ff == S_WR_RD);
      op.elem_addr  = cur_idx_ff;
      op.blk_addr   = cur_blk_ff;
      op.p1_elem    = p1_elem_ff;
      op.p1_whole   = p1_whole_ff;
      op.p1_idx     = p1_idx_ff;
      op.p1_blk     = p1_blk_ff;
      op.fin        = (state_ff == S_ELEM_FIN);
      op.wr_wb      = (state_ff == S_WR_WB);
      op.x          = x_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_sum    = rsp_sum_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// ----- rtl/range_add_range_sum_blocks_top.sv -----
// Range add / range sum over 1024 elements in blocks of 32, one command at a time.
// A command walks its elements inside one block, the partial elements over two adjacent
// blocks, or the partial elements and the whole blocks between them; a write reads and
// writes back one element, and an empty, out-of-range or unknown command goes straight
// to its result. A held result stalls the next one.
// Reset runs a clearing pass over all elements, no transfers. Needs rarbs_pkg, rarbs_ctrl, rarbs_store.
module range_add_range_sum_blocks_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // lo_index[9:0], hi_index[19:10], value[51:20], zeros
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // sum[63:0]
   output logic [0:0]  rsp_tuser,   // status[0]
   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data
);

   rarbs_pkg::op_type             op;
   logic [rarbs_pkg::DATA_W-1:0]  acc;
   logic                          status;

   rarbs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_cmd     (req_tuser),
      .req_lo      (req_tdata[9:0]),
      .req_hi      (req_tdata[19:10]),
      .req_value   (req_tdata[51:20]),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .acc         (acc),
      .op          (op),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_sum     (rsp_tdata),
      .rsp_status  (status)
   );

   rarbs_store u_store (
      .clock (clock),
      .op    (op),
      .acc   (acc)
   );

   assign rsp_tuser = status;

endmodule

// ----- tb/range_add_range_sum_blocks_checker.sv -----
// Checker for the blocked range add / range sum engine: watches the command,
// result and register ports, keeps its own copy of the element array and compares.
// Depends on rarbs_pkg.
module range_add_range_sum_blocks_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [55:0] req_tdata,   // lo_index[9:0], hi_index[19:10], value[51:20], zeros
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,   // sum[63:0]
   input  logic [0:0]  rsp_tuser,   // status[0]
   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data,
   output int          mismatch_count,
   output int          pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   import rarbs_pkg::*;

   typedef struct packed {
      logic [DATA_W-1:0] sum;
      logic              status;
   } range_result_type;

   logic [DATA_W-1:0] elems [MAX_ELEMS];
   logic [DATA_W-1:0] block_totals [NUM_BLOCKS];
   logic [DATA_W-1:0] block_tags [NUM_BLOCKS];
   logic [CFG_W-1:0]  elems_in_use;
   range_result_type  expected_results [$];
   int                errors_seen = 0;

   // Applies one command to the local copy of the array and returns its result.
   task automatic apply_command(input logic [1:0] cmd, input logic [IDX_W-1:0] lo,
                                input logic [IDX_W-1:0] hi_raw,
                                input logic [VAL_W-1:0] value, output range_result_type res);
      int                n, hi, blk_lo, blk_hi, first, last, blk;
      logic [DATA_W-1:0] x, acc, old;
      n = int'(elems_in_use);
      if (n < 1) n = 1;
      if (n > MAX_ELEMS) n = MAX_ELEMS;
      x = {{(DATA_W-VAL_W){value[VAL_W-1]}}, value};
      hi = int'(hi_raw);
      if (hi > n - 1) hi = n - 1;
      res.sum = '0;
      res.status = STATUS_DONE;
      case (cmd)
         CMD_ADD, CMD_SUM: begin
            if (lo > hi) begin
               res.status = STATUS_EMPTY;
            end else begin
               acc = '0;
               blk_lo = int'(lo) >> BLOCK_BITS;
               blk_hi = hi >> BLOCK_BITS;
               for (int b = blk_lo; b <= blk_hi; b++) begin
                  if (b > blk_lo && b < blk_hi) begin
                     // Interior blocks are covered whole: only the tag and total move.
                     if (cmd == CMD_ADD) begin
                        block_tags[b] += x;
                        block_totals[b] += x << BLOCK_BITS;
                     end else begin
                        acc += block_totals[b];
                     end
                  end else begin
                     first = (b == blk_lo) ? int'(lo) : b * BLK_ELEMS;
                     last = (b == blk_hi) ? hi : b * BLK_ELEMS + BLK_ELEMS - 1;
                     for (int i = first; i <= last; i++) begin
                        if (cmd == CMD_ADD) begin
                           elems[i] += x;
                           block_totals[b] += x;
                        end else begin
                           acc += elems[i] + block_tags[b];
                        end
                     end
                  end
               end
               if (cmd == CMD_SUM) res.sum = acc;
            end
         end
         CMD_WRITE: begin
            if (lo >= n) begin
               res.status = STATUS_EMPTY;
            end else begin
               // The stored element excludes the block tag, so the tag is taken out here.
               blk = int'(lo) >> BLOCK_BITS;
               old = elems[lo] + block_tags[blk];
               elems[lo] = x - block_tags[blk];
               block_totals[blk] += x - old;
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : monitor
      range_result_type oldest, fresh;
      if (reset) begin
         for (int i = 0; i < MAX_ELEMS; i++) elems[i] = '0;
         for (int b = 0; b < NUM_BLOCKS; b++) begin
            block_totals[b] = '0;
            block_tags[b] = '0;
         end
         elems_in_use = CFG_W'(MAX_ELEMS);
         expected_results.delete();
      end else begin
         if (csr_wr_en) elems_in_use = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("result transfer with no command outstanding: sum %h status %0d",
                      rsp_tdata, rsp_tuser[0]);
               errors_seen++;
            end else begin
               oldest = expected_results.pop_front();
               if (rsp_tdata !== oldest.sum) begin
                  $error("sum mismatch: expected %h, actual %h", oldest.sum, rsp_tdata);
                  errors_seen++;
               end
               if (rsp_tuser[0] !== oldest.status) begin
                  $error("status mismatch: expected %0d, actual %0d", oldest.status,
                         rsp_tuser[0]);
                  errors_seen++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            apply_command(req_tuser, req_tdata[9:0], req_tdata[19:10], req_tdata[51:20],
                          fresh);
            expected_results.push_back(fresh);
         end
      end
      pending_results <= expected_results.size();
      mismatch_count <= errors_seen;
   end

endmodule

// ----- tb/range_add_range_sum_blocks_top_test.sv -----
// Stimulus and verdict for the blocked range add / range sum engine.
// Depends on rarbs_pkg, range_add_range_sum_blocks_top and
// range_add_range_sum_blocks_checker.
module range_add_range_sum_blocks_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import rarbs_pkg::*;

   localparam logic [1:0] CMD_UNKNOWN = 2'd3;
   localparam int PHASE_ITEMS = 133;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES = 120;
   localparam int LONG_HOLD_CYCLES = 600;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;   // lo_index[9:0], hi_index[19:10], value[51:20], zeros
   logic [1:0]  req_tuser;   // cmd[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // sum[63:0]
   logic [0:0]  rsp_tuser;   // status[0]
   logic        csr_wr_en;
   logic [10:0] csr_wr_data;
   int          mismatch_count;
   int          pending_results;

   int          burst_left = 1;
   bit          offering = 0;
   int          elems_used = MAX_ELEMS;

   range_add_range_sum_blocks_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   range_add_range_sum_blocks_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .mismatch_count(mismatch_count), .pending_results(pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("range_add_range_sum_blocks_top_test: FAIL");
      $finish;
   end

   // Result side: segments of differing readiness, plus one long hold-off
   // once a few hundred results have gone by, so that commands back up.
   initial begin : result_sink
      int  seen, mode, span;
      bit  long_done, ready_now;
      seen = 0;
      long_done = 0;
      forever begin
         mode = $urandom_range(0, 3);
         span = (mode == 3) ? $urandom_range(1, 40) : $urandom_range(16, 128);
         if (!long_done && seen >= 300) begin
            mode = 3;
            span = LONG_HOLD_CYCLES;
            long_done = 1;
         end
         repeat (span) begin
            case (mode)
               0: ready_now = 1'b1;
               1: ready_now = 1'($urandom_range(0, 1));
               2: ready_now = ($urandom_range(0, 3) == 0);
               default: ready_now = 1'b0;
            endcase
            rsp_tready <= ready_now;
            @(posedge clock);
            if (rsp_tvalid && rsp_tready) seen++;
         end
      end
   end

   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return '0;
         3: return '1;
         4, 5, 6: return $urandom_range(0, 2000) - 1000;
         default: return $urandom;
      endcase
   endfunction

   // Offers one command and returns once it has transferred; the valid stays high while
   // the current burst lasts, and a pause follows the end of each burst.
   task automatic send_item(input logic [1:0] cmd, input logic [IDX_W-1:0] lo,
                            input logic [IDX_W-1:0] hi, input logic [VAL_W-1:0] value);
      req_tuser <= cmd;
      req_tdata <= {4'b0, value, hi, lo};
      if (!offering) req_tvalid <= 1'b1;
      offering = 1;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      if (burst_left <= 0) begin
         req_tvalid <= 1'b0;
         offering = 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
   endtask

   task automatic wait_idle();
      if (offering) begin
         req_tvalid <= 1'b0;
         offering = 0;
      end
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   task automatic set_elems_in_use(input logic [CFG_W-1:0] count);
      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= count;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      elems_used = int'(count);
      if (elems_used < 1) elems_used = 1;
      if (elems_used > MAX_ELEMS) elems_used = MAX_ELEMS;
   endtask

   // Mostly in-range adds, sums and writes; the rest are empty, clamped or
   // unknown commands.
   task automatic send_random();
      int         pick, lo, hi;
      logic [1:0] cmd;
      pick = $urandom_range(0, 99);
      lo = $urandom_range(0, elems_used - 1);
      if (pick < 78) begin
         if ($urandom_range(0, 2) == 0) begin
            hi = lo + $urandom_range(0, 40);
            if (hi > MAX_ELEMS - 1) hi = MAX_ELEMS - 1;
         end else begin
            hi = $urandom_range(lo, MAX_ELEMS - 1);
         end
         cmd = (pick < 35) ? CMD_ADD : (pick < 62) ? CMD_SUM : CMD_WRITE;
         if (cmd == CMD_WRITE) hi = $urandom_range(0, MAX_ELEMS - 1);
      end else begin
         lo = $urandom_range(0, MAX_ELEMS - 1);
         hi = $urandom_range(0, MAX_ELEMS - 1);
         cmd = (pick < 94) ? 2'($urandom_range(0, 2)) : CMD_UNKNOWN;
      end
      send_item(cmd, IDX_W'(lo), IDX_W'(hi), pick_value());
   endtask

   initial begin : stimulus
      int phase_counts[10];
      phase_counts = '{1024, 1, 0, 2047, 32, 33, 64, 1000, 1023, 0};
      phase_counts[9] = $urandom_range(1, 1024);
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= CMD_ADD;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part, all elements in use.
      send_item(CMD_WRITE, 0, 0, 32'h7FFF_FFFF);
      send_item(CMD_WRITE, 1023, 0, 32'h8000_0000);
      send_item(CMD_WRITE, 31, 1023, -32'sd5);
      send_item(CMD_ADD, 0, 1023, 32'd3);
      send_item(CMD_ADD, 3, 3, 32'h8000_0000);
      send_item(CMD_ADD, 5, 20, 32'h7FFF_FFFF);
      send_item(CMD_ADD, 30, 100, '1);
      send_item(CMD_SUM, 0, 1023, '0);
      send_item(CMD_SUM, 3, 3, '0);
      send_item(CMD_SUM, 31, 32, '0);
      send_item(CMD_SUM, 5, 20, '0);
      send_item(CMD_SUM, 10, 1000, '0);
      // Block 1 carries a tag here, so the write must take it into account.
      send_item(CMD_WRITE, 40, 0, 32'd123);
      send_item(CMD_SUM, 32, 63, '0);
      send_item(CMD_ADD, 1023, 0, 32'd1);
      send_item(CMD_SUM, 600, 599, '0);
      send_item(CMD_UNKNOWN, 1023, 1023, '1);
      send_item(CMD_SUM, 1023, 1023, '0);
      // Fewer elements in use: clamped high index, start beyond use, write beyond use.
      set_elems_in_use(1000);
      send_item(CMD_SUM, 990, 1023, '0);
      send_item(CMD_ADD, 1000, 1010, 32'd7);
      send_item(CMD_WRITE, 1010, 0, 32'd9);
      send_item(CMD_WRITE, 999, 0, 32'h8000_0000);
      send_item(CMD_SUM, 0, 1023, '0);
      send_item(CMD_ADD, 998, 1023, 32'h7FFF_FFFF);
      send_item(CMD_SUM, 960, 1023, '0);

      foreach (phase_counts[p]) begin
         set_elems_in_use(CFG_W'(phase_counts[p]));
         repeat (PHASE_ITEMS) send_random();
      end

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("range_add_range_sum_blocks_top_test: PASS");
      end else begin
         $display("range_add_range_sum_blocks_top_test: FAIL");
      end
      $finish;
   end

endmodule

// ----- range_add_range_sum_blocks_top.f -----
rtl/rarbs_pkg.sv
rtl/rarbs_ram.sv
rtl/rarbs_store.sv
rtl/rarbs_ctrl.sv
rtl/range_add_range_sum_blocks_top.sv
tb/range_add_range_sum_blocks_checker.sv
tb/range_add_range_sum_blocks_top_test.sv
